// ----- rtl/pcb_pkg.sv -----
// Shared types, constants and helper functions for the plane corner bounds block.
package pcb_pkg;

   // |normal_y| * 1000 > 999 * 16384 holds exactly when |normal_y| >= 16368
   localparam logic [16:0] UP_SWAP_MIN = 17'd16368;
   localparam logic [30:0] HALF_EXTENT_RESET = 31'd65536000;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 31;

   // one vector ready for the length unit: largest magnitude scaled up to >= 2^30
   typedef struct packed {
      logic zero;
      logic [2:0] neg;
      logic [2:0][31:0] mag;
   } pcb_vec_type;

   // payload walking down the square root cells
   typedef struct packed {
      pcb_vec_type [1:0] vec;
      logic [2:0][31:0] point;
      logic [1:0][63:0] rad;
      logic [1:0][63:0] root;
   } pcb_sqrt_type;

   // payload walking down the divider cells
   typedef struct packed {
      logic [1:0] zero;
      logic [1:0][2:0] neg;
      logic [1:0][31:0] len;
      logic [1:0][2:0][32:0] rem;
      logic [1:0][2:0][30:0] quo;
      logic [2:0][31:0] point;
   } pcb_div_type;

   // scale a vector up until its largest magnitude reaches 2^30
   function automatic pcb_vec_type pcb_unit_prep(logic [2:0][31:0] m, logic [2:0] n);
      pcb_vec_type res;
      logic [31:0] orv;
      logic [4:0] msb;
      logic [4:0] sh;
      orv = m[0] | m[1] | m[2];
      msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (orv[i]) begin
            msb = 5'(i);
         end
      end
      sh = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
      res.zero = (orv == 32'd0);
      res.neg = n;
      for (int c = 0; c < 3; c++) begin
         res.mag[c] = m[c] << sh;
      end
      return res;
   endfunction

   // clamp to the signed 32 bit range
   function automatic logic [31:0] pcb_sat(logic signed [34:0] v);
      logic [31:0] res;
      if (v > 35'sd2147483647) begin
         res = 32'h7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/pcb_front.sv -----
// Front stages: up vector choice, cross products, scaling, squares and length sums.
module pcb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [143:0]          in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pcb_pkg::pcb_sqrt_type out_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [15:0] nx, ny, nz;
   logic signed [16:0] ex, ey, ez;
   logic [16:0] ay;
   logic flip;
   logic signed [16:0] r_c [3];
   logic signed [33:0] f_c [3];

   logic signed [16:0] r1_ff [3];
   logic signed [33:0] f1_ff [3];
   logic [2:0][31:0] p1_ff, p2_ff, p3_ff;

   logic [2:0][31:0] rm, fm;
   logic [2:0] rn, fn;
   logic [16:0] rt [3];
   logic [33:0] ft [3];
   pcb_pkg::pcb_vec_type v2_in [2];
   pcb_pkg::pcb_vec_type v2_ff [2];
   pcb_pkg::pcb_vec_type v3_ff [2];
   logic [1:0][2:0][63:0] sq3_ff;
   pcb_pkg::pcb_sqrt_type s4_ff;

   // stage advances when empty or when the next one moves
   assign rdy4 = !s4_valid_ff || out_ready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;
   assign out_valid = s4_valid_ff;
   assign out_data = s4_ff;

   // up vector choice and unnormalized right / forward
   always_comb begin
      nx = in_data[15:0];
      ny = in_data[31:16];
      nz = in_data[47:32];
      ex = {nx[15], nx};
      ey = {ny[15], ny};
      ez = {nz[15], nz};
      ay = ey[16] ? (~ey + 17'd1) : ey;
      flip = (ay >= pcb_pkg::UP_SWAP_MIN);
      if (flip) begin
         r_c[0] = 17'sd0;
         r_c[1] = ez;
         r_c[2] = -ey;
      end else begin
         r_c[0] = -ez;
         r_c[1] = 17'sd0;
         r_c[2] = ex;
      end
      f_c[0] = r_c[1] * ez - r_c[2] * ey;
      f_c[1] = r_c[2] * ex - r_c[0] * ez;
      f_c[2] = r_c[0] * ey - r_c[1] * ex;
   end

   // magnitudes and scaling toward 2^30
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rt[c] = r1_ff[c][16] ? (~r1_ff[c] + 17'd1) : r1_ff[c];
         ft[c] = f1_ff[c][33] ? (~f1_ff[c] + 34'd1) : f1_ff[c];
         rm[c] = {15'd0, rt[c]};
         fm[c] = ft[c][31:0];
         rn[c] = r1_ff[c][16];
         fn[c] = f1_ff[c][33];
      end
      v2_in[0] = pcb_pkg::pcb_unit_prep(rm, rn);
      v2_in[1] = pcb_pkg::pcb_unit_prep(fm, fn);
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
      if (rdy1) begin
         r1_ff <= r_c;
         f1_ff <= f_c;
         p1_ff <= in_data[143:48];
      end
      if (rdy2) begin
         v2_ff <= v2_in;
         p2_ff <= p1_ff;
      end
      if (rdy3) begin
         v3_ff <= v2_ff;
         p3_ff <= p2_ff;
         for (int v = 0; v < 2; v++) begin
            for (int c = 0; c < 3; c++) begin
               sq3_ff[v][c] <= 64'(v2_ff[v].mag[c]) * 64'(v2_ff[v].mag[c]);
            end
         end
      end
      if (rdy4) begin
         s4_ff.vec[0] <= v3_ff[0];
         s4_ff.vec[1] <= v3_ff[1];
         s4_ff.point <= p3_ff;
         for (int v = 0; v < 2; v++) begin
            s4_ff.rad[v] <= sq3_ff[v][0] + sq3_ff[v][1] + sq3_ff[v][2];
            s4_ff.root[v] <= 64'd0;
         end
      end
   end

endmodule

// ----- rtl/pcb_sqrt_cell.sv -----
// One cell of the square root chain: one result bit for both vectors.
module pcb_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pcb_pkg::pcb_sqrt_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pcb_pkg::pcb_sqrt_type out_data
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic valid_ff;
   pcb_pkg::pcb_sqrt_type data_ff, data_in;
   logic [63:0] trial [2];

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   // restoring square root step
   always_comb begin
      data_in = in_data;
      for (int v = 0; v < 2; v++) begin
         trial[v] = in_data.root[v] + BIT;
         if (in_data.rad[v] >= trial[v]) begin
            data_in.rad[v] = in_data.rad[v] - trial[v];
            data_in.root[v] = (in_data.root[v] >> 1) + BIT;
         end else begin
            data_in.root[v] = in_data.root[v] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/pcb_div_cell.sv -----
// One cell of the divider chain: one quotient bit for all six components.
module pcb_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pcb_pkg::pcb_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pcb_pkg::pcb_div_type out_data
);

   logic valid_ff;
   pcb_pkg::pcb_div_type data_ff, data_in;
   logic [32:0] part;
   logic qbit;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   // compare, subtract, shift
   always_comb begin
      data_in = in_data;
      part = 33'd0;
      qbit = 1'b0;
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < 3; c++) begin
            qbit = (in_data.rem[v][c] >= {1'b0, in_data.len[v]});
            part = qbit ? (in_data.rem[v][c] - {1'b0, in_data.len[v]}) : in_data.rem[v][c];
            data_in.rem[v][c] = {part[31:0], 1'b0};
            data_in.quo[v][c] = {in_data.quo[v][c][29:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/pcb_back.sv -----
// Back stages: offset scaling by half_extent, corner sums, saturation, output register.
module pcb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [30:0]          half_extent,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pcb_pkg::pcb_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [191:0]         out_data
);

   logic b1_valid_ff, b2_valid_ff;
   logic rdy1, rdy2;
   logic signed [31:0] ru [3];
   logic signed [31:0] fu [3];
   logic signed [32:0] d [3];
   logic [32:0] dm [3];
   logic [62:0] prod_in [3];
   logic [62:0] prod_ff [3];
   logic [2:0] dneg_ff;
   logic [2:0][31:0] p1_ff;
   logic signed [34:0] off [3];
   logic signed [34:0] pw [3];
   logic [191:0] out_in, out_ff;

   assign rdy2 = !b2_valid_ff || out_ready;
   assign rdy1 = !b1_valid_ff || rdy2;
   assign in_ready = rdy1;
   assign out_valid = b2_valid_ff;
   assign out_data = out_ff;

   // signed unit components, their sum and the scaled magnitude
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (in_data.zero[0]) begin
            ru[c] = 32'sd0;
         end else begin
            ru[c] = in_data.neg[0][c] ? -$signed({1'b0, in_data.quo[0][c]})
                                      : $signed({1'b0, in_data.quo[0][c]});
         end
         if (in_data.zero[1]) begin
            fu[c] = 32'sd0;
         end else begin
            fu[c] = in_data.neg[1][c] ? -$signed({1'b0, in_data.quo[1][c]})
                                      : $signed({1'b0, in_data.quo[1][c]});
         end
         d[c] = 33'(ru[c]) + 33'(fu[c]);
         dm[c] = d[c][32] ? (~d[c] + 33'd1) : d[c];
         prod_in[c] = 63'(half_extent) * 63'(dm[c][31:0]);
      end
   end

   // offsets truncated toward zero, corners saturated
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         off[c] = dneg_ff[c] ? -$signed({2'b00, prod_ff[c][62:30]})
                             : $signed({2'b00, prod_ff[c][62:30]});
         pw[c] = 35'($signed(p1_ff[c]));
         out_in[32 * c +: 32] = pcb_pkg::pcb_sat(pw[c] - off[c]);
         out_in[96 + 32 * c +: 32] = pcb_pkg::pcb_sat(pw[c] + off[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         if (rdy1) b1_valid_ff <= in_valid;
         if (rdy2) b2_valid_ff <= b1_valid_ff;
      end
      if (rdy1) begin
         prod_ff <= prod_in;
         p1_ff <= in_data.point;
         for (int c = 0; c < 3; c++) begin
            dneg_ff[c] <= d[c][32];
         end
      end
      if (rdy2) begin
         out_ff <= out_in;
      end
   end

endmodule

// ----- rtl/plane_corner_bounds_top.sv -----
// Top level: plane patch corners from a normal and a point, as a chain of pipeline cells.
// Stages from an accepted req beat to its rsp beat: 4 front stages,
// 32 square root cells, 31 divider cells, 2 back stages.
// Throughput: one beat per cycle while rsp_tready is high; each cell holds one item and passes it on, and
// the output register lets new beats enter while a result waits.
// Reset: clears every valid bit and sets half_extent to 1000.0 (Q16.16).
module plane_corner_bounds_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // normal_x, normal_y, normal_z (16 each), point_x, point_y, point_z (32 each)
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point - offset x, y, z, then point + offset x, y, z (32 each)
   output logic [191:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam int NS = pcb_pkg::SQRT_STEPS;
   localparam int ND = pcb_pkg::DIV_STEPS;

   logic [30:0] half_extent_ff;
   logic [NS:0] sq_valid, sq_ready;
   pcb_pkg::pcb_sqrt_type sq_data [NS + 1];
   logic [ND:0] dv_valid, dv_ready;
   pcb_pkg::pcb_div_type dv_data [ND + 1];

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         half_extent_ff <= pcb_pkg::HALF_EXTENT_RESET;
      end else if (csr_valid && csr_ready) begin
         half_extent_ff <= csr_data[30:0];
      end
   end

   pcb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_data  (sq_data[0])
   );

   // square root chain
   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      pcb_sqrt_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_ready  (sq_ready[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i + 1]),
         .out_ready (sq_ready[i + 1]),
         .out_data  (sq_data[i + 1])
      );
   end

   // hand lengths and scaled magnitudes to the divider chain
   assign dv_valid[0] = sq_valid[NS];
   assign sq_ready[NS] = dv_ready[0];
   always_comb begin
      dv_data[0].point = sq_data[NS].point;
      for (int v = 0; v < 2; v++) begin
         dv_data[0].zero[v] = sq_data[NS].vec[v].zero;
         dv_data[0].neg[v] = sq_data[NS].vec[v].neg;
         dv_data[0].len[v] = sq_data[NS].root[v][31:0];
         for (int c = 0; c < 3; c++) begin
            dv_data[0].rem[v][c] = {1'b0, sq_data[NS].vec[v].mag[c]};
            dv_data[0].quo[v][c] = 31'd0;
         end
      end
   end

   // divider chain
   for (genvar i = 0; i < ND; i++) begin : g_div
      pcb_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[i]),
         .in_ready  (dv_ready[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i + 1]),
         .out_ready (dv_ready[i + 1]),
         .out_data  (dv_data[i + 1])
      );
   end

   pcb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_extent (half_extent_ff),
      .in_valid    (dv_valid[ND]),
      .in_ready    (dv_ready[ND]),
      .in_data     (dv_data[ND]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata)
   );

   // intake stops only when every cell is full and the output is held
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with room in the chain");

   // the root of a 64 bit radicand fits 32 bits
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      sq_valid[NS] |-> (sq_data[NS].root[0][63:32] == 32'd0 &&
                        sq_data[NS].root[1][63:32] == 32'd0))
      else $error("square root exceeds 32 bits");

   // right vector unit components never exceed one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (dv_valid[ND] && !dv_data[ND].zero[0]) |->
         (dv_data[ND].quo[0][0] <= 31'h4000_0000 &&
          dv_data[ND].quo[0][1] <= 31'h4000_0000 &&
          dv_data[ND].quo[0][2] <= 31'h4000_0000))
      else $error("right component above one");

   // a register write lands on the next edge
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> (half_extent_ff == $past(csr_data[30:0])))
      else $error("half_extent write lost");

endmodule
